>>> hdl/rexu_pkg.sv
package rexu_pkg;

  localparam int ADDR_BITS_DEF = 12;
  localparam int DATA_BITS_DEF = 32;

  localparam int OPC_W  = 5;
  localparam int WORD_W = 32;
  localparam int PC_W   = 12;
  localparam int KIND_W = 3;

  typedef enum logic [OPC_W-1:0] {
    OP_ADD  = 5'd0,
    OP_SUB  = 5'd1,
    OP_MUL  = 5'd2,
    OP_AND  = 5'd3,
    OP_OR   = 5'd4,
    OP_XOR  = 5'd5,
    OP_SLL  = 5'd6,
    OP_SRA  = 5'd7,
    OP_SRL  = 5'd8,
    OP_BEQ  = 5'd9,
    OP_BNE  = 5'd10,
    OP_BLT  = 5'd11,
    OP_BGT  = 5'd12,
    OP_BLE  = 5'd13,
    OP_BGE  = 5'd14,
    OP_JAL  = 5'd15,
    OP_LW   = 5'd16,
    OP_SW   = 5'd17,
    OP_RETI = 5'd18,
    OP_IN   = 5'd19,
    OP_OUT  = 5'd20,
    OP_HALT = 5'd21
  } opcode_t;

  typedef enum logic [KIND_W-1:0] {
    ACC_NONE     = 3'd0,
    ACC_MEM_RD   = 3'd1,
    ACC_MEM_WR   = 3'd2,
    ACC_IO_RD    = 3'd3,
    ACC_IO_WR    = 3'd4
  } access_kind_t;

  typedef struct packed {
    logic        [OPC_W-1:0]  req_type;
    logic signed [WORD_W-1:0] rs_value;
    logic signed [WORD_W-1:0] rt_value;
    logic signed [WORD_W-1:0] rd_value;
    logic        [PC_W-1:0]   pc_now;
    logic        [PC_W-1:0]   irq_return_addr;
  } req_t;

  typedef struct packed {
    logic                     reg_write;
    logic signed [WORD_W-1:0] reg_value;
    logic                     branch_taken;
    logic        [PC_W-1:0]   branch_target;
    logic        [KIND_W-1:0] access_kind;
    logic        [PC_W-1:0]   access_addr;
    logic signed [WORD_W-1:0] store_data;
    logic                     halt_request;
    logic                     irq_end;
  } rsp_t;

endpackage

>>> hdl/rexu_alu.sv
module rexu_alu #(
  parameter int ADDR_BITS = rexu_pkg::ADDR_BITS_DEF,
  parameter int DATA_BITS = rexu_pkg::DATA_BITS_DEF
) (
  input  rexu_pkg::req_t req,
  output rexu_pkg::rsp_t rsp
);
  import rexu_pkg::*;

  localparam int RW = (DATA_BITS < WORD_W) ? DATA_BITS : WORD_W;
  localparam int AW = (ADDR_BITS < PC_W) ? ADDR_BITS : PC_W;
  localparam logic [PC_W-1:0] AMASK = PC_W'((64'd1 << AW) - 64'd1);

  logic [RW-1:0]        a;
  logic [RW-1:0]        b;
  logic [RW-1:0]        d;
  logic [RW-1:0]        sum;
  logic [RW-1:0]        diff;
  logic [RW-1:0]        prod;
  logic [RW-1:0]        val;
  logic [DATA_BITS-1:0] rs_x;
  logic [DATA_BITS-1:0] srl_full;
  logic [DATA_BITS-1:0] sra_full;
  logic [4:0]           sh;
  logic                 eq;
  logic                 lt;
  logic                 gt;
  logic                 cond;

  assign a    = req.rs_value[RW-1:0];
  assign b    = req.rt_value[RW-1:0];
  assign d    = req.rd_value[RW-1:0];
  assign sh   = req.rt_value[4:0];
  assign rs_x = DATA_BITS'(req.rs_value);

  assign sum      = a + b;
  assign diff     = a - b;
  assign prod     = a * b;
  assign srl_full = rs_x >> sh;
  assign sra_full = $signed(rs_x) >>> sh;

  assign eq = (a == b);
  assign lt = ($signed(a) < $signed(b));
  assign gt = ($signed(b) < $signed(a));

  always_comb begin
    rsp  = '0;
    val  = '0;
    cond = 1'b0;
    unique case (opcode_t'(req.req_type))
      OP_ADD:  val = sum;
      OP_SUB:  val = diff;
      OP_MUL:  val = prod;
      OP_AND:  val = a & b;
      OP_OR:   val = a | b;
      OP_XOR:  val = a ^ b;
      OP_SLL:  val = a << sh;
      OP_SRA:  val = sra_full[RW-1:0];
      OP_SRL:  val = srl_full[RW-1:0];
      OP_BEQ:  cond = eq;
      OP_BNE:  cond = !eq;
      OP_BLT:  cond = lt;
      OP_BGT:  cond = gt;
      OP_BLE:  cond = !gt;
      OP_BGE:  cond = !lt;
      OP_JAL: begin
        rsp.reg_write     = 1'b1;
        rsp.reg_value     = WORD_W'(req.pc_now);
        rsp.branch_taken  = 1'b1;
        rsp.branch_target = req.rs_value[PC_W-1:0] & AMASK;
      end
      OP_LW: begin
        rsp.access_kind = ACC_MEM_RD;
        rsp.access_addr = sum[PC_W-1:0] & AMASK;
      end
      OP_SW: begin
        rsp.access_kind = ACC_MEM_WR;
        rsp.access_addr = sum[PC_W-1:0] & AMASK;
        rsp.store_data  = WORD_W'(d);
      end
      OP_RETI: begin
        rsp.branch_taken  = 1'b1;
        rsp.branch_target = req.irq_return_addr & AMASK;
        rsp.irq_end       = 1'b1;
      end
      OP_IN: begin
        rsp.access_kind = ACC_IO_RD;
        rsp.access_addr = sum[PC_W-1:0] & AMASK;
      end
      OP_OUT: begin
        rsp.access_kind = ACC_IO_WR;
        rsp.access_addr = sum[PC_W-1:0] & AMASK;
        rsp.store_data  = WORD_W'(d);
      end
      OP_HALT: rsp.halt_request = 1'b1;
      default: ;
    endcase

    if (req.req_type <= OP_SRL) begin
      rsp.reg_write = 1'b1;
      rsp.reg_value = WORD_W'(val);
    end
    if (cond) begin
      rsp.branch_taken  = 1'b1;
      rsp.branch_target = req.rd_value[PC_W-1:0] & AMASK;
    end
  end

endmodule

>>> hdl/risc_execute_unit_core.sv
// A transfer is held in the input register, then passes the ALU into the result register.
// Throughput: one instruction per cycle while the output is not stalled; the decode, ALU and
// compare logic sits in a single pass between the two registers, and the input side keeps
// taking transfers while a result waits, as long as the input register is empty.
// Reset: synchronous, active low; clears both valid flags, payload registers are not reset.
module risc_execute_unit_core #(
  parameter int ADDR_BITS = rexu_pkg::ADDR_BITS_DEF,
  parameter int DATA_BITS = rexu_pkg::DATA_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rexu_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rexu_pkg::rsp_t out_data
);
  import rexu_pkg::*;

  req_t req_r;
  logic req_vld_r;
  rsp_t rsp_r;
  rsp_t rsp_nxt;
  logic out_vld_r;
  logic out_adv;

  rexu_alu #(
    .ADDR_BITS (ADDR_BITS),
    .DATA_BITS (DATA_BITS)
  ) u_alu (
    .req (req_r),
    .rsp (rsp_nxt)
  );

  assign out_adv  = !out_vld_r || out_ready;
  assign in_ready = !req_vld_r || out_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        req_vld_r <= in_valid;
      end
      if (out_adv) begin
        out_vld_r <= req_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_data;
    end
    if (out_adv && req_vld_r) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = rsp_r;

endmodule

>>> hdl/rexu_chk.sv
module rexu_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input rexu_pkg::rsp_t out_data
);
  import rexu_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // stall the input only when the result side is blocked
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> ##1 out_valid)
    else $error("accepted transfer did not reach the output");

  a_halt_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.halt_request |->
      !out_data.reg_write && !out_data.branch_taken && !out_data.irq_end &&
      (out_data.access_kind == ACC_NONE))
    else $error("halt result carries other effects");

endmodule

bind risc_execute_unit_core rexu_chk u_chk (.*);
